// File: rtl/core/binary_bcd_converter_96bit_macros.svh
// Assertion macros used by the converter's top-level RTL file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BINARY_BCD_CONVERTER_96BIT_MACROS_SVH
`define BINARY_BCD_CONVERTER_96BIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Converter assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Converter assertion failed.");

`endif

// File: rtl/core/bbc_pkg.sv
package bbc_pkg;

    localparam int BIN_BITS        = 96;
    localparam int DIGIT_W         = 4;
    localparam int MAX_DIGITS      = 30;
    localparam int MAX_BCD_W       = MAX_DIGITS * DIGIT_W;
    localparam int STEPS_PER_STAGE = 8;
    localparam int NUM_STAGES      = BIN_BITS / STEPS_PER_STAGE;

    localparam logic [DIGIT_W-1:0] FWD_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] REV_LIMIT = 4'd8;
    localparam logic [DIGIT_W-1:0] ADJUST    = 4'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    localparam logic MODE_BIN_TO_BCD = 1'b0;
    localparam logic MODE_BCD_TO_BIN = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_BAD_DIGIT = 2'd2;

    typedef logic [MAX_BCD_W-1:0] bcd_full_t;

    typedef struct packed {
        logic       mode;
        logic       bad_digit;
        logic [7:0] scale;
        logic       sign;
    } bbc_ctrl_t;

endpackage

// File: rtl/core/bbc_stage.sv
module bbc_stage #(
    parameter int BCD_DIGITS = 30
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bbc_pkg::bbc_ctrl_t            in_ctrl,
    input  logic [BCD_DIGITS*4-1:0]       in_bcd,
    input  logic [bbc_pkg::BIN_BITS-1:0]  in_bin,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bbc_pkg::bbc_ctrl_t            out_ctrl,
    output logic [BCD_DIGITS*4-1:0]       out_bcd,
    output logic [bbc_pkg::BIN_BITS-1:0]  out_bin
);

    localparam int BCD_W = BCD_DIGITS * bbc_pkg::DIGIT_W;
    localparam int BIN_W = bbc_pkg::BIN_BITS;
    localparam int DW    = bbc_pkg::DIGIT_W;

    logic               valid_reg;
    bbc_pkg::bbc_ctrl_t ctrl_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   bcd_next;
    logic [BIN_W-1:0]   bin_reg;
    logic [BIN_W-1:0]   bin_next;

    // Eight shift steps per stage, each step in the direction the item's mode selects.
    always_comb
    begin
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
        logic [DW-1:0]    dig;
        bcd = in_bcd;
        bin = in_bin;
        dig = '0;
        for (int s = 0; s < bbc_pkg::STEPS_PER_STAGE; s++)
        begin
            if (in_ctrl.mode == bbc_pkg::MODE_BIN_TO_BCD)
            begin
                for (int d = 0; d < BCD_DIGITS; d++)
                begin
                    dig = bcd[d*DW +: DW];
                    if (dig >= bbc_pkg::FWD_LIMIT)
                    begin
                        bcd[d*DW +: DW] = dig + bbc_pkg::ADJUST;
                    end
                end
                bcd = {bcd[BCD_W-2:0], bin[BIN_W-1]};
                bin = {bin[BIN_W-2:0], 1'b0};
            end
            else
            begin
                bin = {bcd[0], bin[BIN_W-1:1]};
                bcd = {1'b0, bcd[BCD_W-1:1]};
                for (int d = 0; d < BCD_DIGITS; d++)
                begin
                    dig = bcd[d*DW +: DW];
                    if (dig >= bbc_pkg::REV_LIMIT)
                    begin
                        bcd[d*DW +: DW] = dig - bbc_pkg::ADJUST;
                    end
                end
            end
        end
        bcd_next = bcd;
        bin_next = bin;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ctrl_reg <= in_ctrl;
            bcd_reg  <= bcd_next;
            bin_reg  <= bin_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_bcd   = bcd_reg;
    assign out_bin   = bin_reg;

endmodule

// File: rtl/core/binary_bcd_converter_96bit.sv
// Converts a 96-bit unsigned binary magnitude to packed BCD (tuser low) or packed BCD
// to binary (tuser high), with scale and sign carried along unchanged. The core is a
// twelve-stage pipeline in which every stage performs eight shift-and-adjust steps, so
// one transaction is accepted every cycle while the output side does not stall, and
// each result passes through the stage registers in order. A stall holds occupied
// stages, empty ones still fill, and nothing is lost or repeated. In the BCD direction a
// digit above nine sets status to invalid and clears the binary result, and a value of
// 2^96 or more sets status to overflow while the binary result keeps the low 96 bits.
`include "binary_bcd_converter_96bit_macros.svh"

module binary_bcd_converter_96bit #(
    parameter int BCD_DIGITS = 30
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // bin_low, bin_mid, bin_high, bcd_low, bcd_high, scale_in, sign_in, zero fill.
    input  logic [231:0] s_axis_tdata,
    // mode.
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // res_bin_low, res_bin_mid, res_bin_high, res_bcd_low, res_bcd_high, scale_out,
    // sign_out, status, zero fill.
    output logic [231:0] m_axis_tdata
);

    localparam int BCD_W   = BCD_DIGITS * bbc_pkg::DIGIT_W;
    localparam int BIN_W   = bbc_pkg::BIN_BITS;
    localparam int DW      = bbc_pkg::DIGIT_W;
    localparam int NSTAGES = bbc_pkg::NUM_STAGES;

    logic               valid_s [0:NSTAGES];
    logic               ready_s [0:NSTAGES];
    bbc_pkg::bbc_ctrl_t ctrl_s  [0:NSTAGES];
    logic [BCD_W-1:0]   bcd_s   [0:NSTAGES];
    logic [BIN_W-1:0]   bin_s   [0:NSTAGES];

    bbc_pkg::bcd_full_t in_digits;
    logic               bad_digit;

    assign in_digits = {s_axis_tdata[215:156], s_axis_tdata[155:96]};

    always_comb
    begin
        bad_digit = 1'b0;
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (in_digits[d*DW +: DW] > bbc_pkg::DIGIT_MAX)
            begin
                bad_digit = 1'b1;
            end
        end
    end

    assign valid_s[0]          = s_axis_tvalid;
    assign s_axis_tready       = ready_s[0];
    assign ctrl_s[0].mode      = s_axis_tuser;
    assign ctrl_s[0].bad_digit = bad_digit;
    assign ctrl_s[0].scale     = s_axis_tdata[223:216];
    assign ctrl_s[0].sign      = s_axis_tdata[224];
    assign bcd_s[0] = (s_axis_tuser == bbc_pkg::MODE_BCD_TO_BIN) ? in_digits[BCD_W-1:0] : '0;
    assign bin_s[0] = (s_axis_tuser == bbc_pkg::MODE_BCD_TO_BIN) ? '0 : s_axis_tdata[95:0];

    for (genvar k = 0; k < NSTAGES; k++)
    begin : g_stage
        bbc_stage #(
            .BCD_DIGITS (BCD_DIGITS)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_s[k]),
            .in_ready  (ready_s[k]),
            .in_ctrl   (ctrl_s[k]),
            .in_bcd    (bcd_s[k]),
            .in_bin    (bin_s[k]),
            .out_valid (valid_s[k+1]),
            .out_ready (ready_s[k+1]),
            .out_ctrl  (ctrl_s[k+1]),
            .out_bcd   (bcd_s[k+1]),
            .out_bin   (bin_s[k+1])
        );
    end

    bbc_pkg::bbc_ctrl_t last_ctrl;
    logic [1:0]         status;
    bbc_pkg::bcd_full_t res_bcd;
    logic [BIN_W-1:0]   res_bin;

    assign last_ctrl = ctrl_s[NSTAGES];

    always_comb
    begin
        status  = bbc_pkg::STATUS_OK;
        res_bcd = '0;
        res_bin = '0;
        if (last_ctrl.mode == bbc_pkg::MODE_BIN_TO_BCD)
        begin
            res_bcd = bbc_pkg::bcd_full_t'(bcd_s[NSTAGES]);
        end
        else if (last_ctrl.bad_digit)
        begin
            status = bbc_pkg::STATUS_BAD_DIGIT;
        end
        else
        begin
            res_bin = bin_s[NSTAGES];
            if (|bcd_s[NSTAGES])
            begin
                status = bbc_pkg::STATUS_OVERFLOW;
            end
        end
    end

    assign ready_s[NSTAGES] = m_axis_tready;
    assign m_axis_tvalid    = valid_s[NSTAGES];
    assign m_axis_tdata     = {5'b0, status, last_ctrl.sign, last_ctrl.scale, res_bcd, res_bin};

    `BBC_ASSERT_IMPLY(a_status_no_bcd, m_axis_tvalid && (status != bbc_pkg::STATUS_OK), res_bcd == '0)
    `BBC_ASSERT_IMPLY(a_bad_digit_no_bin, m_axis_tvalid && (status == bbc_pkg::STATUS_BAD_DIGIT), res_bin == '0)
    `BBC_ASSERT_IMPLY(a_empty_out_takes_input, !m_axis_tvalid, s_axis_tready)
    `BBC_ASSERT_IMPLY(a_drain_takes_input, m_axis_tready, s_axis_tready)

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int BCD_DIGITS    = 30;
    localparam int DRAIN_CYCLES  = 50;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic        mode;
        logic [31:0] bin_low;
        logic [31:0] bin_mid;
        logic [31:0] bin_high;
        logic [59:0] bcd_low;
        logic [59:0] bcd_high;
        logic [7:0]  scale;
        logic        sign;
    } conv_item_t;

    typedef struct packed {
        logic [31:0] bin_low;
        logic [31:0] bin_mid;
        logic [31:0] bin_high;
        logic [59:0] bcd_low;
        logic [59:0] bcd_high;
        logic [7:0]  scale;
        logic        sign;
        logic [1:0]  status;
    } conv_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [231:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [231:0] m_axis_tdata;

    conv_result_t pending_results[$];
    conv_result_t expected_result;
    int           mismatch_count;
    int           cycle_count;
    int           sender_idle_pct;
    int           receiver_stall_pct;

    binary_bcd_converter_96bit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [119:0] to_packed_bcd(logic [127:0] value);
        logic [119:0] digits;
        logic [127:0] rem;
        digits = '0;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            rem = value % 10;
            digits[4*i +: 4] = rem[3:0];
            value = value / 10;
        end
        return digits;
    endfunction

    function automatic conv_result_t predict_conversion(conv_item_t item);
        conv_result_t result;
        logic [119:0] digits;
        logic [127:0] value;
        logic         bad_digit;
        result        = '0;
        result.scale  = item.scale;
        result.sign   = item.sign;
        result.status = bbc_pkg::STATUS_OK;
        if (item.mode == bbc_pkg::MODE_BIN_TO_BCD)
        begin
            digits = to_packed_bcd({32'd0, item.bin_high, item.bin_mid, item.bin_low});
            result.bcd_low  = digits[59:0];
            result.bcd_high = digits[119:60];
        end
        else
        begin
            digits    = {item.bcd_high, item.bcd_low};
            value     = '0;
            bad_digit = 1'b0;
            for (int i = BCD_DIGITS - 1; i >= 0; i--)
            begin
                if (digits[4*i +: 4] > bbc_pkg::DIGIT_MAX)
                    bad_digit = 1'b1;
                value = value * 10 + digits[4*i +: 4];
            end
            if (bad_digit)
                result.status = bbc_pkg::STATUS_BAD_DIGIT;
            else
            begin
                {result.bin_high, result.bin_mid, result.bin_low} = value[95:0];
                if (value[127:96] != 0)
                    result.status = bbc_pkg::STATUS_OVERFLOW;
            end
        end
        return result;
    endfunction

    function automatic conv_item_t make_item(logic mode, logic [95:0] bin,
                                             logic [119:0] bcd, logic [7:0] scale,
                                             logic sign);
        conv_item_t item;
        item.mode     = mode;
        item.bin_low  = bin[31:0];
        item.bin_mid  = bin[63:32];
        item.bin_high = bin[95:64];
        item.bcd_low  = bcd[59:0];
        item.bcd_high = bcd[119:60];
        item.scale    = scale;
        item.sign     = sign;
        return item;
    endfunction

    function automatic conv_item_t random_item(logic mode);
        logic [127:0] bin_raw;
        logic [127:0] bcd_raw;
        logic [119:0] digits;
        logic [127:0] value;
        int           kind;
        int           count;
        int           pos;
        bin_raw = {$urandom, $urandom, $urandom, $urandom};
        bcd_raw = {$urandom, $urandom, $urandom, $urandom};
        digits  = bcd_raw[119:0];
        if (mode == bbc_pkg::MODE_BIN_TO_BCD)
        begin
            if ($urandom_range(3) != 0)
            begin
                count   = $urandom_range(96);
                bin_raw = bin_raw & ((128'd1 << count) - 1);
            end
        end
        else
        begin
            kind = $urandom_range(99);
            if (kind < 90)
            begin
                count  = $urandom_range(BCD_DIGITS);
                digits = '0;
                for (int i = 0; i < count; i++)
                    digits[4*i +: 4] = 4'($urandom_range(9));
            end
            if (kind >= 55 && kind < 75)
            begin
                value  = (128'd1 << 96) - 128'd1000 + 128'($urandom_range(2000));
                digits = to_packed_bcd(value);
            end
            else if (kind >= 75 && kind < 90)
            begin
                pos = $urandom_range(BCD_DIGITS - 1);
                digits[4*pos +: 4] = 4'($urandom_range(15, 10));
            end
        end
        return make_item(mode, bin_raw[95:0], digits, 8'($urandom_range(255)),
                         1'($urandom_range(1)));
    endfunction

    task automatic note_mismatch(string field, logic [63:0] expected, logic [63:0] actual);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("Mismatch in %s at %0t: expected %h, got %h",
                     field, $time, expected, actual);
    endtask

    task automatic check_field(string field, logic [63:0] expected, logic [63:0] actual);
        if (expected !== actual)
            note_mismatch(field, expected, actual);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                note_mismatch("unexpected transaction", '0, m_axis_tdata[63:0]);
            else
            begin
                expected_result = pending_results.pop_front();
                check_field("res_bin_low", expected_result.bin_low, m_axis_tdata[31:0]);
                check_field("res_bin_mid", expected_result.bin_mid, m_axis_tdata[63:32]);
                check_field("res_bin_high", expected_result.bin_high, m_axis_tdata[95:64]);
                check_field("res_bcd_low", expected_result.bcd_low, m_axis_tdata[155:96]);
                check_field("res_bcd_high", expected_result.bcd_high,
                            m_axis_tdata[215:156]);
                check_field("scale_out", expected_result.scale, m_axis_tdata[223:216]);
                check_field("sign_out", expected_result.sign, m_axis_tdata[224]);
                check_field("status", expected_result.status, m_axis_tdata[226:225]);
            end
        end
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);

    task automatic send_conversion(conv_item_t item);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= item.mode;
        s_axis_tdata  <= {7'd0, item.sign, item.scale, item.bcd_high, item.bcd_low,
                          item.bin_high, item.bin_mid, item.bin_low};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(predict_conversion(item));
        @(negedge clk);
    endtask

    // The sender holds off until every outstanding transaction has come back.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic test_directed_cases();
        logic [127:0] ten_pow_28;
        logic [127:0] two_pow_96;
        logic [119:0] digits;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        ten_pow_28 = 128'd1;
        repeat (28) ten_pow_28 = ten_pow_28 * 10;
        two_pow_96 = 128'd1 << 96;

        send_conversion(make_item(bbc_pkg::MODE_BIN_TO_BCD, '0, '0, 8'd0, 1'b0));
        send_conversion(make_item(bbc_pkg::MODE_BIN_TO_BCD, 96'd1, '1, 8'd255, 1'b1));
        send_conversion(make_item(bbc_pkg::MODE_BIN_TO_BCD, '1, '0, 8'd255, 1'b1));
        send_conversion(make_item(bbc_pkg::MODE_BIN_TO_BCD, ten_pow_28[95:0], '0,
                                  8'd7, 1'b0));
        send_conversion(make_item(bbc_pkg::MODE_BIN_TO_BCD, ten_pow_28[95:0] - 1, '0,
                                  8'd1, 1'b1));
        send_conversion(make_item(bbc_pkg::MODE_BIN_TO_BCD, {24{4'h5}}, '1, 8'h55, 1'b0));
        send_conversion(make_item(bbc_pkg::MODE_BIN_TO_BCD, {24{4'hA}}, '0, 8'hAA, 1'b1));

        send_conversion(make_item(bbc_pkg::MODE_BCD_TO_BIN, '1, '0, 8'd0, 1'b0));
        send_conversion(make_item(bbc_pkg::MODE_BCD_TO_BIN, '0, 120'd1, 8'd255, 1'b1));
        send_conversion(make_item(bbc_pkg::MODE_BCD_TO_BIN, '0,
                                  to_packed_bcd(two_pow_96 - 1), 8'd3, 1'b0));
        send_conversion(make_item(bbc_pkg::MODE_BCD_TO_BIN, '0,
                                  to_packed_bcd(two_pow_96), 8'd4, 1'b1));
        send_conversion(make_item(bbc_pkg::MODE_BCD_TO_BIN, '0, {30{4'h9}}, 8'd128, 1'b0));
        digits = '0;
        digits[119:116] = 4'd1;
        send_conversion(make_item(bbc_pkg::MODE_BCD_TO_BIN, '0, digits, 8'd9, 1'b1));
        digits = {30{4'h9}};
        digits[3:0] = 4'hA;
        send_conversion(make_item(bbc_pkg::MODE_BCD_TO_BIN, '1, digits, 8'd10, 1'b0));
        digits = '0;
        digits[119:116] = 4'hF;
        send_conversion(make_item(bbc_pkg::MODE_BCD_TO_BIN, '0, digits, 8'd11, 1'b1));
        send_conversion(make_item(bbc_pkg::MODE_BCD_TO_BIN, '0, '1, 8'd255, 1'b1));
        digits = '0;
        digits[63:56] = 8'h99;
        send_conversion(make_item(bbc_pkg::MODE_BCD_TO_BIN, '0, digits, 8'd12, 1'b0));
        digits = '0;
        digits[59:56] = 4'hC;
        send_conversion(make_item(bbc_pkg::MODE_BCD_TO_BIN, '0, digits, 8'd13, 1'b1));
        digits = '0;
        digits[63:60] = 4'hB;
        send_conversion(make_item(bbc_pkg::MODE_BCD_TO_BIN, '0, digits, 8'd14, 1'b0));
        send_conversion(make_item(bbc_pkg::MODE_BCD_TO_BIN, '0, {15{8'h10}}, 8'd15, 1'b1));
        wait_for_drain();
    endtask

    task automatic test_binary_to_bcd();
        sender_idle_pct    = 63;
        receiver_stall_pct = 0;
        repeat (400) send_conversion(random_item(bbc_pkg::MODE_BIN_TO_BCD));
        wait_for_drain();
    endtask

    task automatic test_bcd_to_binary();
        sender_idle_pct    = 0;
        receiver_stall_pct = 63;
        repeat (500) send_conversion(random_item(bbc_pkg::MODE_BCD_TO_BIN));
        wait_for_drain();
    endtask

    task automatic test_mixed_traffic();
        sender_idle_pct    = 35;
        receiver_stall_pct = 35;
        repeat (500) send_conversion(random_item(1'($urandom_range(1))));
        wait_for_drain();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (500) send_conversion(random_item(1'($urandom_range(1))));
        wait_for_drain();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        s_axis_tvalid      = 1'b0;
        s_axis_tdata       = '0;
        s_axis_tuser       = 1'b0;
        m_axis_tready      = 1'b0;
        mismatch_count     = 0;
        cycle_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_binary_to_bcd();
        test_bcd_to_binary();
        test_mixed_traffic();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/bbc_pkg.sv
rtl/core/bbc_stage.sv
rtl/core/binary_bcd_converter_96bit.sv
test/testbench.sv
